>>> src/ssc_pkg.sv
// ----------------------------------------------------------------------------
// Strided subview start checker package
// Widths, status codes and the status type shared by all files of the block.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int DATA_W   = 64;
    localparam int HALF_W   = DATA_W / 2;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK            = 3'd0,
        STATUS_BAD_ARG       = 3'd1,
        STATUS_INDEX_OVF     = 3'd2,
        STATUS_EXCEEDS_SHAPE = 3'd3,
        STATUS_START_OVF     = 3'd4
    } status_t;

endpackage

>>> src/ssc_if.sv
// ----------------------------------------------------------------------------
// Strided subview start checker channels
// Dimension input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssc_dim_if;
    logic                                valid;
    logic                                ready;
    logic signed [ssc_pkg::DATA_W-1:0]   view_offset;
    logic signed [ssc_pkg::DATA_W-1:0]   view_size;
    logic signed [ssc_pkg::DATA_W-1:0]   view_stride;
    logic signed [ssc_pkg::DATA_W-1:0]   source_extent;
    logic signed [ssc_pkg::DATA_W-1:0]   source_step;
    logic                                last_dim;

    modport source (
        output valid, view_offset, view_size, view_stride,
        output source_extent, source_step, last_dim,
        input  ready
    );
    modport sink (
        input  valid, view_offset, view_size, view_stride,
        input  source_extent, source_step, last_dim,
        output ready
    );
endinterface

interface ssc_res_if;
    logic                              valid;
    logic                              ready;
    logic [ssc_pkg::DATA_W-1:0]        start_element;
    logic [ssc_pkg::STATUS_W-1:0]      status;

    modport source (
        output valid, start_element, status,
        input  ready
    );
    modport sink (
        input  valid, start_element, status,
        output ready
    );
endinterface

>>> src/ssc_mul_ovf.sv
// ----------------------------------------------------------------------------
// Two-stage unsigned multiplier with overflow flag
// Forms a 64 x 64 product from 32 x 32 partial products over two register
// stages and flags any product that does not fit in 64 bits.
// ----------------------------------------------------------------------------
module ssc_mul_ovf (
    input  logic                         clk,
    input  logic                         en_a,
    input  logic                         en_b,
    input  logic [ssc_pkg::DATA_W-1:0]   a,
    input  logic [ssc_pkg::DATA_W-1:0]   b,
    output logic [ssc_pkg::DATA_W-1:0]   product,
    output logic                         ovf
);

    localparam int HW = ssc_pkg::HALF_W;
    localparam int DW = ssc_pkg::DATA_W;

    logic [DW-1:0]      pll_reg, pll_next;
    logic [DW-1:0]      plh_reg, plh_next;
    logic [DW-1:0]      phl_reg, phl_next;
    logic               hh_nz_reg, hh_nz_next;
    logic [DW-1:0]      product_reg, product_next;
    logic               ovf_reg, ovf_next;

    logic [DW:0]        mid_sum;
    logic [DW+HW:0]     full_sum;

    always_comb
    begin
        pll_next   = DW'(a[HW-1:0]) * DW'(b[HW-1:0]);
        plh_next   = DW'(a[HW-1:0]) * DW'(b[DW-1:HW]);
        phl_next   = DW'(a[DW-1:HW]) * DW'(b[HW-1:0]);
        hh_nz_next = (a[DW-1:HW] != '0) && (b[DW-1:HW] != '0);
    end

    // The high-high partial product lands at bit 64 or above, so it only
    // matters through whether it is nonzero.
    always_comb
    begin
        mid_sum      = {1'b0, plh_reg} + {1'b0, phl_reg};
        full_sum     = {mid_sum, {HW{1'b0}}} + {{(HW+1){1'b0}}, pll_reg};
        product_next = full_sum[DW-1:0];
        ovf_next     = hh_nz_reg || (full_sum[DW+HW:DW] != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            pll_reg   <= pll_next;
            plh_reg   <= plh_next;
            phl_reg   <= phl_next;
            hh_nz_reg <= hh_nz_next;
        end
        if (en_b)
        begin
            product_reg <= product_next;
            ovf_reg     <= ovf_next;
        end
    end

    assign product = product_reg;
    assign ovf     = ovf_reg;

endmodule

>>> src/strided_subview_start_checker_top.sv
// ----------------------------------------------------------------------------
// Strided subview start checker
// Checks one subview dimension per transfer against the source buffer and
// accumulates the linear start element; reports it with a status code on the
// dimension marked last.
// ----------------------------------------------------------------------------
// Path: a result passes the input register, two multiplier stages and
//   the result register after the transfer of its last dimension.
// Throughput: one dimension per cycle while no last dimension waits on a full
//   result register; the 64-bit accumulate in the last stage is combinational.
// Reset: rst_n clears all stage valids, the result valid, the start
//   accumulator and the latched error; no result is pending after reset.
module strided_subview_start_checker_top (
    input  logic       clk,
    input  logic       rst_n,
    ssc_dim_if.sink    dim,
    ssc_res_if.source  res
);

    localparam int DW = ssc_pkg::DATA_W;

    // Stage 1: input register
    logic                 s1_valid_reg, s1_valid_next;
    logic [DW-1:0]        s1_off_reg, s1_size_reg, s1_str_reg, s1_ext_reg, s1_sstep_reg;
    logic                 s1_last_reg;

    // Stage 2: first multiplier stage, argument check
    logic                 s2_valid_reg, s2_valid_next;
    logic [DW-1:0]        s2_off_reg, s2_ext_reg;
    logic                 s2_bad_reg, s2_bad_next;
    logic                 s2_last_reg;

    // Stage 3: products ready
    logic                 s3_valid_reg, s3_valid_next;
    logic [DW-1:0]        s3_off_reg, s3_ext_reg;
    logic                 s3_bad_reg;
    logic                 s3_last_reg;

    // Subview state and result register
    logic [DW-1:0]        accum_reg, accum_next;
    ssc_pkg::status_t     err_reg, err_next;
    logic                 res_valid_reg, res_valid_next;
    logic [DW-1:0]        res_start_reg, res_start_next;
    ssc_pkg::status_t     res_status_reg, res_status_next;

    logic                 out_free;
    logic                 s1_adv, s2_adv, s3_adv, s3_fire;

    logic [DW-1:0]        span, prod;
    logic                 span_ovf, prod_ovf;

    logic [DW:0]          last_idx;
    logic [DW:0]          accum_sum;
    ssc_pkg::status_t     dim_code;
    logic [DW-1:0]        accum_upd;

    // Ready chain: a stage moves on when the stage after it is empty or moves
    // too. Only a last dimension needs room in the result register.
    always_comb
    begin
        out_free = !res_valid_reg || res.ready;
        s3_adv   = !s3_valid_reg || !s3_last_reg || out_free;
        s2_adv   = !s2_valid_reg || s3_adv;
        s1_adv   = !s1_valid_reg || s2_adv;
        s3_fire  = s3_valid_reg && s3_adv;
    end

    assign dim.ready = s1_adv;

    always_comb
    begin
        s1_valid_next = s1_adv ? dim.valid : s1_valid_reg;
        s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_adv ? s2_valid_reg : s3_valid_reg;
    end

    always_comb
    begin
        s2_bad_next = s1_off_reg[DW-1] || s1_size_reg[DW-1] || (s1_size_reg == '0) ||
                      s1_str_reg[DW-1] || s1_sstep_reg[DW-1] || s1_ext_reg[DW-1] ||
                      (s1_off_reg >= s1_ext_reg);
    end

    ssc_mul_ovf u_span_mul (
        .clk     (clk),
        .en_a    (s2_adv),
        .en_b    (s3_adv),
        .a       (s1_size_reg - DW'(1)),
        .b       (s1_str_reg),
        .product (span),
        .ovf     (span_ovf)
    );

    ssc_mul_ovf u_start_mul (
        .clk     (clk),
        .en_a    (s2_adv),
        .en_b    (s3_adv),
        .a       (s1_off_reg),
        .b       (s1_sstep_reg),
        .product (prod),
        .ovf     (prod_ovf)
    );

    // Checks of one dimension in priority order; the start overflow check
    // is the only one that sees the accumulated state.
    always_comb
    begin
        last_idx  = {1'b0, s3_off_reg} + {1'b0, span};
        accum_sum = {1'b0, accum_reg} + {1'b0, prod};

        if (s3_bad_reg)
            dim_code = ssc_pkg::STATUS_BAD_ARG;
        else if (span_ovf || last_idx[DW])
            dim_code = ssc_pkg::STATUS_INDEX_OVF;
        else if (last_idx[DW-1:0] >= s3_ext_reg)
            dim_code = ssc_pkg::STATUS_EXCEEDS_SHAPE;
        else if (prod_ovf || accum_sum[DW])
            dim_code = ssc_pkg::STATUS_START_OVF;
        else
            dim_code = ssc_pkg::STATUS_OK;
    end

    always_comb
    begin
        err_next        = err_reg;
        accum_next      = accum_reg;
        accum_upd       = accum_reg;
        res_start_next  = res_start_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg && !res.ready;

        if (s3_fire)
        begin
            // Once an error is latched, later dimensions of the subview are ignored.
            if (err_reg == ssc_pkg::STATUS_OK)
            begin
                err_next = dim_code;
                if (dim_code == ssc_pkg::STATUS_OK)
                    accum_upd = accum_sum[DW-1:0];
            end
            accum_next = accum_upd;

            if (s3_last_reg)
            begin
                res_valid_next  = 1'b1;
                res_status_next = err_next;
                res_start_next  = (err_next == ssc_pkg::STATUS_OK) ? accum_upd : '0;
                err_next        = ssc_pkg::STATUS_OK;
                accum_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            accum_reg     <= '0;
            err_reg       <= ssc_pkg::STATUS_OK;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            res_valid_reg <= res_valid_next;
            accum_reg     <= accum_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_off_reg   <= dim.view_offset;
            s1_size_reg  <= dim.view_size;
            s1_str_reg   <= dim.view_stride;
            s1_ext_reg   <= dim.source_extent;
            s1_sstep_reg <= dim.source_step;
            s1_last_reg  <= dim.last_dim;
        end
        if (s2_adv)
        begin
            s2_off_reg  <= s1_off_reg;
            s2_ext_reg  <= s1_ext_reg;
            s2_bad_reg  <= s2_bad_next;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_adv)
        begin
            s3_off_reg  <= s2_off_reg;
            s3_ext_reg  <= s2_ext_reg;
            s3_bad_reg  <= s2_bad_reg;
            s3_last_reg <= s2_last_reg;
        end
        res_start_reg  <= res_start_next;
        res_status_reg <= res_status_next;
    end

    assign res.valid         = res_valid_reg;
    assign res.start_element = res_start_reg;
    assign res.status        = res_status_reg;

endmodule

>>> src/ssc_checker.sv
// ----------------------------------------------------------------------------
// Strided subview start checker assertions
// Port-level checks of the dimension and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module ssc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             dim_valid,
    input  logic                             dim_ready,
    input  logic                             res_valid,
    input  logic                             res_ready,
    input  logic [ssc_pkg::DATA_W-1:0]       start_element,
    input  logic [ssc_pkg::STATUS_W-1:0]     status
);

    // A cycle that sees reset low is followed by one with no result pending.
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("result valid after reset");

    // The input side always gives a defined answer to an offered transfer.
    a_dim_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        dim_valid |-> !$isunknown(dim_ready))
        else $error("dimension ready unknown");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status <= ssc_pkg::STATUS_START_OVF))
        else $error("status code out of range");

    // A failed subview reports a zero start element.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status != ssc_pkg::STATUS_OK)) |-> (start_element == '0))
        else $error("nonzero start element with error status");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(start_element) && $stable(status)))
        else $error("stalled result changed");

endmodule

bind strided_subview_start_checker_top ssc_checker u_ssc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .dim_valid     (dim.valid),
    .dim_ready     (dim.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .start_element (res.start_element),
    .status        (res.status)
);
